>>> rtl/core/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// No dependencies; used by bpc_button and button_press_classifier_core.
package bpc_pkg;

  localparam int CNT_W    = 10;
  localparam int RAW_W    = 3;
  localparam int BTN_W    = 3;
  localparam int KIND_W   = 2;
  localparam int FLAG_W   = 4;
  localparam int TALLY_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS  = 2'd3;

  // Actions
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // Event flag bit positions (match the poll kind codes)
  localparam int FLAG_SINGLE = 0;
  localparam int FLAG_LONG   = 1;
  localparam int FLAG_DOUBLE = 2;
  localparam int FLAG_REPEAT = 3;

  // Reset values
  localparam logic             RST_PRESSED_LEVEL = 1'b0;
  localparam logic [CNT_W-1:0] RST_LONG_TICKS    = 10'd100;
  localparam logic [CNT_W-1:0] RST_DOUBLE_TICKS  = 10'd30;
  localparam logic [CNT_W-1:0] RST_REPEAT_TICKS  = 10'd50;
  localparam logic             RELEASED_RAW      = 1'b1;
  localparam logic [TALLY_W-1:0] TALLY_DOUBLE    = 2'd2;

  typedef struct packed {
    logic              action;
    logic [RAW_W-1:0]  raw_levels;
    logic [BTN_W-1:0]  button;
    logic [KIND_W-1:0] event_kind;
  } in_item_t;

  typedef struct packed {
    logic             flag_seen;
    logic [RAW_W-1:0] held_mask;
  } out_item_t;

  typedef struct packed {
    logic             pressed_level;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] double_window_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } cfg_t;

  // Per-button command for one step
  typedef struct packed {
    logic              step;
    logic              tick;
    logic              raw;
    logic              poll;
    logic [KIND_W-1:0] kind;
  } btn_cmd_t;

endpackage

>>> rtl/core/bpc_button.sv
// Per-button state and update: debounce, single/double/long/repeat flags.
// Depends on bpc_pkg.
module bpc_button (
  input  logic              clk,
  input  logic              rst_n,
  input  bpc_pkg::cfg_t     cfg,
  input  bpc_pkg::btn_cmd_t cmd,
  output logic              flag_seen,
  output logic              held_nxt
);

  logic [2:0]                      hist_r, hist_nxt;
  logic                            stable_r, stable_nxt;
  logic [bpc_pkg::CNT_W-1:0]       long_r, long_nxt;
  logic                            holding_r, holding_nxt;
  logic [bpc_pkg::CNT_W-1:0]       rep_r, rep_nxt;
  logic [bpc_pkg::CNT_W-1:0]       dwin_r, dwin_nxt;
  logic [bpc_pkg::TALLY_W-1:0]     tally_r, tally_nxt;
  logic [bpc_pkg::FLAG_W-1:0]      flags_r, flags_nxt;

  always_comb begin
    logic [bpc_pkg::TALLY_W-1:0] t_inc;
    hist_nxt    = hist_r;
    stable_nxt  = stable_r;
    long_nxt    = long_r;
    holding_nxt = holding_r;
    rep_nxt     = rep_r;
    dwin_nxt    = dwin_r;
    tally_nxt   = tally_r;
    flags_nxt   = flags_r;
    flag_seen   = 1'b0;
    t_inc       = tally_r + 2'd1;

    if (cmd.tick) begin
      if (dwin_r != '0) begin
        dwin_nxt = dwin_r - 10'd1;
      end
      hist_nxt = {hist_r[1:0], cmd.raw};
      if (cmd.raw == hist_r[0] && hist_r[0] == hist_r[1]) begin
        if (hist_r[1] != stable_r) begin
          stable_nxt  = hist_r[1];
          holding_nxt = 1'b0;
          rep_nxt     = '0;
          if (hist_r[1] == cfg.pressed_level) begin
            long_nxt = cfg.long_press_ticks;
            flags_nxt[bpc_pkg::FLAG_SINGLE] = 1'b1;
            if (dwin_nxt != '0) begin
              tally_nxt = t_inc;
              if (t_inc == bpc_pkg::TALLY_DOUBLE) begin
                flags_nxt[bpc_pkg::FLAG_DOUBLE] = 1'b1;
                flags_nxt[bpc_pkg::FLAG_SINGLE] = 1'b0;
                tally_nxt = '0;
                dwin_nxt  = '0;
              end
            end else begin
              tally_nxt = 2'd1;
              dwin_nxt  = cfg.double_window_ticks;
            end
          end else begin
            flags_nxt[bpc_pkg::FLAG_LONG]   = 1'b0;
            flags_nxt[bpc_pkg::FLAG_REPEAT] = 1'b0;
          end
        end else if (stable_r == cfg.pressed_level) begin
          if (!holding_r) begin
            long_nxt = long_r - 10'd1;
            if (long_nxt == '0) begin
              flags_nxt[bpc_pkg::FLAG_LONG]   = 1'b1;
              flags_nxt[bpc_pkg::FLAG_SINGLE] = 1'b0;
              holding_nxt = 1'b1;
              dwin_nxt    = '0;
              tally_nxt   = '0;
              rep_nxt     = cfg.repeat_ticks;
            end
          end
          if (holding_nxt) begin
            // first repeat counts down in the same tick the long flag fires
            if (rep_nxt <= 10'd1) begin
              rep_nxt = cfg.repeat_ticks;
              flags_nxt[bpc_pkg::FLAG_REPEAT] = 1'b1;
            end else begin
              rep_nxt = rep_nxt - 10'd1;
            end
          end
        end
      end
    end else if (cmd.poll) begin
      if (flags_r[cmd.kind]) begin
        flag_seen = 1'b1;
        flags_nxt[cmd.kind] = 1'b0;
      end
    end

    held_nxt = (stable_nxt == cfg.pressed_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= {3{bpc_pkg::RELEASED_RAW}};
      stable_r  <= bpc_pkg::RELEASED_RAW;
      long_r    <= bpc_pkg::RST_LONG_TICKS;
      holding_r <= 1'b0;
      rep_r     <= '0;
      dwin_r    <= '0;
      tally_r   <= '0;
      flags_r   <= '0;
    end else if (cmd.step) begin
      hist_r    <= hist_nxt;
      stable_r  <= stable_nxt;
      long_r    <= long_nxt;
      holding_r <= holding_nxt;
      rep_r     <= rep_nxt;
      dwin_r    <= dwin_nxt;
      tally_r   <= tally_nxt;
      flags_r   <= flags_nxt;
    end
  end

endmodule

>>> rtl/core/button_press_classifier_core.sv
// Button press classifier core (uses bpc_pkg and bpc_button). Each input
// transaction is either a tick, which samples the raw pin level of every button,
// debounces it over three equal samples and advances the single, double, long-press
// and auto-repeat tracking, or a poll, which returns one sticky event flag of one
// button and clears it. Every transaction produces exactly one result carrying
// flag_seen (always 0 on a tick) and held_mask, the debounced pressed state after
// the update. The block takes one transaction per cycle while out_ready stays high:
// a transaction is captured in an input register, and the per-button update is one
// shallow pass of logic feeding the result register. Write configuration registers
// through cfg_* only while no transaction is in flight.
module button_press_classifier_core #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bpc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bpc_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CNT_W-1:0]         cfg_wdata
);

  // Configuration registers
  bpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level       <= bpc_pkg::RST_PRESSED_LEVEL;
      cfg_r.long_press_ticks    <= bpc_pkg::RST_LONG_TICKS;
      cfg_r.double_window_ticks <= bpc_pkg::RST_DOUBLE_TICKS;
      cfg_r.repeat_ticks        <= bpc_pkg::RST_REPEAT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::CFG_PRESSED_LEVEL: cfg_r.pressed_level       <= cfg_wdata[0];
        bpc_pkg::CFG_LONG_TICKS:    cfg_r.long_press_ticks    <= cfg_wdata;
        bpc_pkg::CFG_DOUBLE_TICKS:  cfg_r.double_window_ticks <= cfg_wdata;
        bpc_pkg::CFG_REPEAT_TICKS:  cfg_r.repeat_ticks        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register stage
  bpc_pkg::in_item_t in_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              advance;
  logic              in_accept;

  // Move the held transaction into the result register when it is free or draining
  assign advance   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
  end

  // Per-button update; state commits only when the transaction advances
  logic [NUM_BUTTONS-1:0] seen_vec;
  logic [NUM_BUTTONS-1:0] held_vec;

  for (genvar n = 0; n < NUM_BUTTONS; n++) begin : g_btn
    bpc_pkg::btn_cmd_t cmd;
    logic              raw_bit;

    // Buttons past the raw input width sample level 0
    if (n < bpc_pkg::RAW_W) begin : g_raw
      assign raw_bit = in_r.raw_levels[n];
    end else begin : g_zero
      assign raw_bit = 1'b0;
    end

    assign cmd.step = advance;
    assign cmd.tick = (in_r.action == bpc_pkg::ACT_TICK);
    assign cmd.raw  = raw_bit;
    assign cmd.poll = (in_r.action == bpc_pkg::ACT_POLL) &&
                      (in_r.button == bpc_pkg::BTN_W'(n));
    assign cmd.kind = in_r.event_kind;

    bpc_button u_btn (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg_r),
      .cmd       (cmd),
      .flag_seen (seen_vec[n]),
      .held_nxt  (held_vec[n])
    );
  end

  // Held mask covers only the buttons that fit the result field
  logic [bpc_pkg::RAW_W-1:0] held_mask;

  for (genvar m = 0; m < bpc_pkg::RAW_W; m++) begin : g_mask
    if (m < NUM_BUTTONS) begin : g_on
      assign held_mask[m] = held_vec[m];
    end else begin : g_off
      assign held_mask[m] = 1'b0;
    end
  end

  // Result register
  bpc_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign out_nxt.flag_seen = |seen_vec;
  assign out_nxt.held_mask = held_mask;

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
